FILE: sv/igcd_pkg.sv
// Shared types and datapath command codes for the integer GCD core.
`default_nettype none

package igcd_pkg;

  // Width of the result word on the output channel
  localparam int OUT_WIDTH = 64;

  typedef logic [OUT_WIDTH-1:0] divisor_t;

  // Datapath operation codes
  localparam logic [2:0] OP_HOLD       = 3'd0;
  localparam logic [2:0] OP_LOAD       = 3'd1;
  localparam logic [2:0] OP_ONE        = 3'd2;
  localparam logic [2:0] OP_COPY_B     = 3'd3;
  localparam logic [2:0] OP_HALVE_BOTH = 3'd4;
  localparam logic [2:0] OP_HALVE_A    = 3'd5;
  localparam logic [2:0] OP_HALVE_B    = 3'd6;
  localparam logic [2:0] OP_REDUCE     = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic       double_en;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_odd;
    logic b_odd;
    logic twos_zero;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/igcd_dp.sv
// Datapath of the integer GCD core: operand registers, shared subtractor, output word.
`default_nettype none

module igcd_dp #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                           clk,
  input  wire logic signed [DATA_WIDTH-1:0]   in_first_value,
  input  wire logic signed [DATA_WIDTH-1:0]   in_second_value,
  input  wire igcd_pkg::cmd_t                 cmd,
  output igcd_pkg::status_t                   status,
  output logic             [igcd_pkg::OUT_WIDTH-1:0] out_divisor
);

  localparam int TW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [TW-1:0]         twos_r, twos_nxt;
  logic [DATA_WIDTH-1:0] mag_first, mag_second;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] out_r;
  logic [igcd_pkg::OUT_WIDTH-1:0] div_r;

  // Magnitude as unsigned: the most negative value maps to 2^(W-1)
  assign mag_first  = in_first_value[DATA_WIDTH-1]  ? DATA_WIDTH'(-in_first_value)
                                                    : DATA_WIDTH'(in_first_value);
  assign mag_second = in_second_value[DATA_WIDTH-1] ? DATA_WIDTH'(-in_second_value)
                                                    : DATA_WIDTH'(in_second_value);

  // b - a with borrow; borrow set means a > b
  assign diff = {1'b0, b_r} - {1'b0, a_r};

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    twos_nxt = twos_r;
    if (cmd.double_en) begin
      a_nxt    = {a_r[DATA_WIDTH-2:0], 1'b0};
      twos_nxt = twos_r - TW'(1);
    end else begin
      case (cmd.op)
        igcd_pkg::OP_LOAD: begin
          a_nxt    = mag_first;
          b_nxt    = mag_second;
          twos_nxt = '0;
        end
        igcd_pkg::OP_ONE: begin
          a_nxt = DATA_WIDTH'(1);
        end
        igcd_pkg::OP_COPY_B: begin
          a_nxt = b_r;
        end
        igcd_pkg::OP_HALVE_BOTH: begin
          a_nxt    = a_r >> 1;
          b_nxt    = b_r >> 1;
          twos_nxt = twos_r + TW'(1);
        end
        igcd_pkg::OP_HALVE_A: begin
          a_nxt = a_r >> 1;
        end
        igcd_pkg::OP_HALVE_B: begin
          b_nxt = b_r >> 1;
        end
        igcd_pkg::OP_REDUCE: begin
          if (diff[DATA_WIDTH]) begin
            // a > b: swap, then take the difference
            a_nxt = b_r;
            b_nxt = DATA_WIDTH'(-diff);
          end else begin
            b_nxt = diff[DATA_WIDTH-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    twos_r <= twos_nxt;
    if (cmd.load_out) begin
      out_r <= a_r;
    end
  end

  assign div_r       = igcd_pkg::divisor_t'(out_r);
  assign out_divisor = div_r;

  assign status.a_zero    = (a_r == '0);
  assign status.b_zero    = (b_r == '0);
  assign status.a_odd     = a_r[0];
  assign status.b_odd     = b_r[0];
  assign status.twos_zero = (twos_r == '0);

endmodule

`default_nettype wire

FILE: sv/igcd_ctrl.sv
// Controller of the integer GCD core: sequencing state machine and output valid.
`default_nettype none

module igcd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire igcd_pkg::status_t status,
  output igcd_pkg::cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TWOS   = 3'd1;
  localparam logic [2:0] ST_STRIP  = 3'd2;
  localparam logic [2:0] ST_REDUCE = 3'd3;
  localparam logic [2:0] ST_SCALE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = igcd_pkg::OP_HOLD;
    cmd.double_en = 1'b0;
    cmd.load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = igcd_pkg::OP_LOAD;
          state_nxt = ST_TWOS;
        end
      end
      ST_TWOS: begin
        if (status.a_zero && status.b_zero) begin
          cmd.op    = igcd_pkg::OP_ONE;
          state_nxt = ST_SCALE;
        end else if (status.a_zero) begin
          cmd.op    = igcd_pkg::OP_COPY_B;
          state_nxt = ST_SCALE;
        end else if (status.b_zero) begin
          state_nxt = ST_SCALE;
        end else if (!status.a_odd && !status.b_odd) begin
          cmd.op = igcd_pkg::OP_HALVE_BOTH;
        end else begin
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (!status.a_odd) begin
          cmd.op = igcd_pkg::OP_HALVE_A;
        end else begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status.b_zero) begin
          state_nxt = ST_SCALE;
        end else if (!status.b_odd) begin
          cmd.op = igcd_pkg::OP_HALVE_B;
        end else begin
          cmd.op = igcd_pkg::OP_REDUCE;
        end
      end
      ST_SCALE: begin
        if (!status.twos_zero) begin
          cmd.double_en = 1'b1;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: sv/integer_gcd_core.sv
// Top level of the integer GCD core: controller, datapath and interface checks.
//
// Usage: present two signed operands on in_first_value and in_second_value with
// in_valid high; the word is taken at a rising edge where in_stall is low. The
// core returns one word on out_divisor: the greatest common divisor of the two
// operand magnitudes (the most negative operand has magnitude 2^(W-1)). Both
// operands zero give 1; exactly one zero gives the magnitude of the other.
// Binary (Stein) method, one step a cycle on a single shared subtract-and-shift
// unit, but for the final step, which can hold on a stalled receiver. Every
// halving drops one bit of the operands, every subtraction but the last is
// followed by at least one halving, and the common factor of two comes back one
// doubling a cycle. One item is worked on at a time and in_stall is high while
// the core is busy, so a new word is taken only once the last one is finished.
// The result sits in an output register, so the core takes the next operand pair
// while a finished word still waits on a stalled receiver; a later result only
// holds in the final step until that register is free.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; the operand registers carry no reset.
`default_nettype none

module integer_gcd_core #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [DATA_WIDTH-1:0]   in_first_value,
  input  wire logic signed [DATA_WIDTH-1:0]   in_second_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic             [igcd_pkg::OUT_WIDTH-1:0] out_divisor
);

  igcd_pkg::cmd_t    cmd;
  igcd_pkg::status_t status;

  // Sequence the steps and own the valid flags
  igcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the operands, shift and subtract, register the result word
  igcd_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .in_first_value  (in_first_value),
    .in_second_value (in_second_value),
    .cmd             (cmd),
    .status          (status),
    .out_divisor     (out_divisor)
  );

  // A gcd of this form is never zero
  a_nonzero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_divisor != '0))
    else $error("zero divisor presented");

  // An accepted word makes the core busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("core free right after accepting a word");

  // A new result appears only at the end of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid ##1 out_valid) |-> $past(in_stall))
    else $error("result word without work in progress");

  // The controller never doubles and loads the output word in the same step
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.double_en && cmd.load_out))
    else $error("double and output load issued together");

endmodule

`default_nettype wire

FILE: sim/integer_gcd_core_tb.sv
// Self-checking testbench for the integer GCD core: random and corner operand words.
`default_nettype none

module integer_gcd_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WIDTH = 64;
  // Allowance in cycles for one word to pass through the core
  localparam int WORD_CYCLES = 4 * DATA_WIDTH + 3;
  // Receiver hold-off: when it starts (in accepted words) and how long it lasts
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 400;
  // Words left in the queue below which neither side idles
  localparam int QUIET_TAIL = 200;
  localparam int RANDOM_WORDS = 1500;
  localparam int PRINT_LIMIT = 100;

  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef struct {
    logic [DATA_WIDTH-1:0] first;
    logic [DATA_WIDTH-1:0] second;
    bit                    drain_first;  // wait for every result before offering
  } operand_pair_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [DATA_WIDTH-1:0]          in_first_value = '0;
  logic [DATA_WIDTH-1:0]          in_second_value = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [igcd_pkg::OUT_WIDTH-1:0] out_divisor;

  operand_pair_t      operand_pairs_q[$];
  igcd_pkg::divisor_t divisor_q[$];
  int                 accepted_words = 0;
  int                 mismatch_count = 0;
  bit                 hold_on = 1'b0;

  integer_gcd_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_first_value (in_first_value),
    .in_second_value(in_second_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_divisor    (out_divisor)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Magnitude of a two's complement operand; the most negative value maps to
  // 2^(W-1) because the negation wraps within W bits and is read as unsigned.
  function automatic igcd_pkg::divisor_t operand_magnitude(logic [DATA_WIDTH-1:0] raw);
    logic [DATA_WIDTH-1:0] v;
    v = raw;
    if (v[DATA_WIDTH-1]) begin
      v = -v;
    end
    return igcd_pkg::divisor_t'(v);
  endfunction

  // Stein's method on the magnitudes; both zero gives 1, one zero gives the other.
  function automatic igcd_pkg::divisor_t gcd_of_magnitudes(logic [DATA_WIDTH-1:0] x,
                                                           logic [DATA_WIDTH-1:0] y);
    igcd_pkg::divisor_t a;
    igcd_pkg::divisor_t b;
    igcd_pkg::divisor_t t;
    int                 twos;
    a = operand_magnitude(x);
    b = operand_magnitude(y);
    twos = 0;
    if (a == '0 && b == '0) begin
      return igcd_pkg::divisor_t'(1);
    end
    if (a == '0) begin
      return b;
    end
    if (b == '0) begin
      return a;
    end
    while (((a | b) & 1) == 0) begin
      a = a >> 1;
      b = b >> 1;
      twos++;
    end
    while (a[0] == 1'b0) begin
      a = a >> 1;
    end
    while (b != '0) begin
      while (b[0] == 1'b0) begin
        b = b >> 1;
      end
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      b = b - a;
    end
    return a << twos;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  task automatic queue_pair(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b,
                            bit drain);
    operand_pair_t p;
    p.first = a;
    p.second = b;
    p.drain_first = drain;
    operand_pairs_q.push_back(p);
  endtask

  function automatic logic [DATA_WIDTH-1:0] random_word();
    return DATA_WIDTH'({$urandom, $urandom});
  endfunction

  // Driver: present one word at a time, hold it while stalled, idle in bursts.
  always @(posedge clk) begin : drive_words
    logic          next_valid;
    bit            free;
    operand_pair_t p;
    int            gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      next_valid = in_valid;
      free = !in_valid;
      if (in_valid && !in_stall) begin
        // Word taken: record what the core must return for it
        divisor_q.push_back(gcd_of_magnitudes(in_first_value, in_second_value));
        accepted_words++;
        free = 1'b1;
        next_valid = 1'b0;
      end
      if (free) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (operand_pairs_q.size() != 0 &&
                     (!operand_pairs_q[0].drain_first || divisor_q.size() == 0)) begin
          p = operand_pairs_q.pop_front();
          in_first_value <= p.first;
          in_second_value <= p.second;
          next_valid = 1'b1;
          // Pick the idle burst that follows this word
          if (operand_pairs_q.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 16);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Long receiver hold-off that fills the core: count it down on its own
  always @(posedge clk) begin : hold_off
    int hold_left;
    bit hold_used;
    if (!rst_n) begin
      hold_left = 0;
      hold_used = 1'b0;
      hold_on <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_used && accepted_words >= HOLD_AFTER) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      hold_on <= (hold_left != 0);
    end
  end

  // Monitor: check each taken result against the oldest prediction, and drive
  // out_stall with random bursts plus the long hold-off.
  always @(posedge clk) begin : check_results
    logic               next_stall;
    igcd_pkg::divisor_t want;
    int                 burst_left;
    if (!rst_n) begin
      out_stall <= 1'b0;
      burst_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (divisor_q.size() == 0) begin
          report_mismatch($sformatf("unexpected divisor %h", out_divisor));
        end else begin
          want = divisor_q.pop_front();
          if (out_divisor !== want) begin
            report_mismatch($sformatf("divisor %h, predicted %h", out_divisor, want));
          end
        end
      end
      if (hold_on) begin
        next_stall = 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        next_stall = 1'b1;
      end else if (operand_pairs_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 15);
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall <= next_stall;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] g;
    bit                    drain;
    int                    drain_at;

    // Directed corners: zeros, extremes, most negative, shared powers of two
    queue_pair('0, '0, 1'b0);
    queue_pair('0, 64'd5, 1'b0);
    queue_pair(-64'sd7, '0, 1'b0);
    queue_pair(MOST_NEG, '0, 1'b0);
    queue_pair('0, MOST_NEG, 1'b0);
    queue_pair(MOST_NEG, MOST_NEG, 1'b0);
    queue_pair(MOST_NEG, MOST_POS, 1'b0);
    queue_pair(MOST_POS, MOST_POS, 1'b0);
    queue_pair(MOST_POS, MOST_POS - 1, 1'b0);
    queue_pair(-MOST_POS, MOST_NEG, 1'b0);
    queue_pair('1, '1, 1'b0);
    queue_pair(64'd1, MOST_NEG, 1'b0);
    queue_pair(MOST_NEG, 64'd1 << 62, 1'b0);
    queue_pair(64'd3 << 40, 64'd1 << 62, 1'b0);
    queue_pair(64'd48, 64'd18, 1'b0);
    queue_pair(-64'sd48, 64'd18, 1'b0);
    queue_pair(64'd12, -64'sd12, 1'b0);
    queue_pair(-64'sd2, 64'd4, 1'b0);
    queue_pair(64'd1, '0, 1'b0);
    queue_pair('0, '1, 1'b0);
    queue_pair(64'd1 << 61, 64'd3 << 61, 1'b0);
    queue_pair(64'd1000000007, 64'd998244353, 1'b0);
    queue_pair(64'd7 << 50, -(64'd21 << 45), 1'b0);
    queue_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);

    // Random part: mix of shapes so that every loop of the method runs deep
    drain_at = $urandom_range(600, 900);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = random_word();
          b = random_word();
        end
        3, 4: begin
          // Large common factor
          g = (random_word() >> $urandom_range(36, 63)) | 1;
          a = g * (random_word() >> $urandom_range(30, 63));
          b = g * (random_word() >> $urandom_range(30, 63));
        end
        5: begin
          // Shared powers of two
          a = (random_word() >> $urandom_range(0, 63)) << $urandom_range(0, 63);
          b = (random_word() >> $urandom_range(0, 63)) << $urandom_range(0, 63);
        end
        6: begin
          a = ($urandom_range(0, 3) == 0) ? '0 : random_word() >> $urandom_range(0, 63);
          b = '0;
          if ($urandom_range(0, 1) == 1) begin
            b = a;
            a = '0;
          end
        end
        7: begin
          a = MOST_NEG;
          b = (random_word() >> $urandom_range(0, 63)) << $urandom_range(0, 63);
          if ($urandom_range(0, 1) == 1) begin
            b = a;
            a = (random_word() >> $urandom_range(0, 63)) << $urandom_range(0, 63);
          end
        end
        8: begin
          a = DATA_WIDTH'($urandom_range(0, 255));
          b = DATA_WIDTH'($urandom_range(0, 255));
        end
        default: begin
          // One operand a small multiple of the other
          a = random_word() >> $urandom_range(8, 63);
          b = a * DATA_WIDTH'($urandom_range(1, 255));
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        a = -a;
      end
      if ($urandom_range(0, 1) == 1) begin
        b = -b;
      end
      drain = (i == drain_at);
      queue_pair(a, b, drain);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every word sent and every result back, then allow for stray words
    @(posedge clk);
    while (operand_pairs_q.size() != 0 || in_valid || divisor_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (WORD_CYCLES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("integer_gcd_core_tb passed");
    end else begin
      $display("integer_gcd_core_tb failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run
  initial begin : watchdog
    #8000000;
    $display("integer_gcd_core_tb failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: integer_gcd_core.f
sv/igcd_pkg.sv
sv/igcd_dp.sv
sv/igcd_ctrl.sv
sv/integer_gcd_core.sv
sim/integer_gcd_core_tb.sv
